>>> rtl/gn2d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn2d_pkg
// Shared constants, types and table functions of the 2D gradient noise core.
// ----------------------------------------------------------------------------
package gn2d_pkg;

   // default geometry
   localparam int DEF_INT_BITS   = 16;
   localparam int DEF_FRAC_BITS  = 16;
   localparam int DEF_ANGLE_BITS = 10;

   // pipeline depth, input register through output register
   localparam int STAGES = 11;

   // corner dot product width, Q23 with headroom
   localparam int DOT_W = 27;

   // corner hash multipliers
   localparam logic [31:0] HASH_M1 = 32'd3284157443;
   localparam logic [31:0] HASH_M2 = 32'd1911520717;
   localparam logic [31:0] HASH_M3 = 32'd2048419325;

   // pi/2 in Q30
   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint Q30_ONE     = 64'sd1 << 30;

   typedef logic [STAGES-1:0] stage_vec_type;

   // swap the two 16-bit halves
   function automatic logic [31:0] rot16(input logic [31:0] v);
      rot16 = {v[15:0], v[31:16]};
   endfunction

   // clamp negative residue, round half up from Q30 to Q15
   function automatic longint q30_to_q15(input longint v);
      longint w;
      w = (v < 0) ? 64'sd0 : v;
      q30_to_q15 = (w + (64'sd1 <<< 14)) >>> 15;
   endfunction

   // one first-quadrant table entry: {cos, sin}, each 17-bit unsigned Q.15 (0..32768)
   function automatic logic [33:0] trig_entry(input int r, input int abits);
      longint x;
      longint x2;
      longint t;
      longint s;
      longint c;
      x  = (longint'(r) * HALF_PI_Q30) >>> (abits - 2);
      x2 = (x * x) >>> 30;
      // sine series, Horner form
      t = Q30_ONE;
      t = Q30_ONE - ((x2 * t) >>> 30) / 110; if (t < 0) t = 0;
      t = Q30_ONE - ((x2 * t) >>> 30) / 72;  if (t < 0) t = 0;
      t = Q30_ONE - ((x2 * t) >>> 30) / 42;  if (t < 0) t = 0;
      t = Q30_ONE - ((x2 * t) >>> 30) / 20;  if (t < 0) t = 0;
      t = Q30_ONE - ((x2 * t) >>> 30) / 6;   if (t < 0) t = 0;
      s = q30_to_q15((x * t) >>> 30);
      // cosine series, Horner form
      t = Q30_ONE;
      t = Q30_ONE - ((x2 * t) >>> 30) / 132; if (t < 0) t = 0;
      t = Q30_ONE - ((x2 * t) >>> 30) / 90;  if (t < 0) t = 0;
      t = Q30_ONE - ((x2 * t) >>> 30) / 56;  if (t < 0) t = 0;
      t = Q30_ONE - ((x2 * t) >>> 30) / 30;  if (t < 0) t = 0;
      t = Q30_ONE - ((x2 * t) >>> 30) / 12;  if (t < 0) t = 0;
      t = Q30_ONE - ((x2 * t) >>> 30) / 2;   if (t < 0) t = 0;
      c = q30_to_q15(t);
      trig_entry = {c[16:0], s[16:0]};
   endfunction

endpackage

>>> rtl/gradient_noise_2d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_noise_2d
// Streaming 2D Perlin gradient noise, Q16.16 point in, Q1.15 sample out.
// ----------------------------------------------------------------------------
// One sample per clock: a point is taken every cycle the result side keeps
// up, and its sample passes through the corner hash, gradient, dot product
// and blend stages in turn. Each stage moves on its own when the one after
// it is empty or moving, so bubbles close up and a stalled output holds only
// what is behind it. No reset of data, only of the valid bits; nothing to
// configure.
module gradient_noise_2d #(
   parameter int INT_BITS   = gn2d_pkg::DEF_INT_BITS,
   parameter int FRAC_BITS  = gn2d_pkg::DEF_FRAC_BITS,
   parameter int ANGLE_BITS = gn2d_pkg::DEF_ANGLE_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_x_coord,
   input  logic signed [31:0] req_y_coord,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_noise_value
);
   import gn2d_pkg::*;

   // per-stage valid bits and advance enables
   stage_vec_type vld_ff, vld_in, adv;

   always_comb begin
      adv[STAGES-1] = !vld_ff[STAGES-1] || !rsp_stall;
      for (int s = STAGES - 2; s >= 0; s--) begin
         adv[s] = !vld_ff[s] || adv[s+1];
      end
      for (int s = 0; s < STAGES; s++) begin
         if (adv[s]) vld_in[s] = (s == 0) ? req_valid : vld_ff[(s == 0) ? 0 : s - 1];
         else        vld_in[s] = vld_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_stall = !adv[0];
   assign rsp_valid = vld_ff[STAGES-1];

   // datapath
   logic [31:0]              hash [4];
   logic [FRAC_BITS-1:0]     fx, fy;
   logic [FRAC_BITS:0]       sx, sy;
   logic signed [DOT_W-1:0]  dot [4];

   gn2d_hash #(.INT_BITS(INT_BITS), .FRAC_BITS(FRAC_BITS)) u_hash (
      .clock    (clock),
      .stage_en (adv[3:0]),
      .point_x  (req_x_coord),
      .point_y  (req_y_coord),
      .hash     (hash),
      .frac_x   (fx),
      .frac_y   (fy)
   );

   gn2d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade (
      .clock    (clock),
      .stage_en (adv[5:0]),
      .frac_x   (req_x_coord[FRAC_BITS-1:0]),
      .frac_y   (req_y_coord[FRAC_BITS-1:0]),
      .fade_x   (sx),
      .fade_y   (sy)
   );

   gn2d_grad #(.FRAC_BITS(FRAC_BITS), .ANGLE_BITS(ANGLE_BITS)) u_grad (
      .clock    (clock),
      .stage_en (adv[5:4]),
      .hash     (hash),
      .frac_x   (fx),
      .frac_y   (fy),
      .dot      (dot)
   );

   gn2d_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
      .clock    (clock),
      .stage_en (adv[10:6]),
      .dot      (dot),
      .fade_x   (sx),
      .fade_y   (sy),
      .noise    (rsp_noise_value)
   );

endmodule

>>> rtl/gn2d_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn2d_hash
// Lattice corners of the point (stage 0) and the multiply/rotate/xor hash of
// each of the four corners, one multiplier rank per stage (stages 1 to 3).
// ----------------------------------------------------------------------------
module gn2d_hash #(
   parameter int INT_BITS  = 16,
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic [3:0]           stage_en,
   input  logic [31:0]          point_x,
   input  logic [31:0]          point_y,
   output logic [31:0]          hash [4],
   output logic [FRAC_BITS-1:0] frac_x,
   output logic [FRAC_BITS-1:0] frac_y
);
   import gn2d_pkg::*;

   // stage 0: floor corners wrapped to INT_BITS, then sign extended
   logic signed [31:0]         shx, shy;
   logic signed [INT_BITS-1:0] wx0, wx1, wy0, wy1;
   logic [31:0] cx0_in, cx1_in, cy0_in, cy1_in;
   logic [31:0] cx0_ff, cx1_ff, cy0_ff, cy1_ff;
   logic [FRAC_BITS-1:0] fx0_ff, fy0_ff;

   always_comb begin
      shx    = signed'(point_x) >>> FRAC_BITS;
      shy    = signed'(point_y) >>> FRAC_BITS;
      wx0    = shx[INT_BITS-1:0];
      wy0    = shy[INT_BITS-1:0];
      wx1    = wx0 + INT_BITS'(1);
      wy1    = wy0 + INT_BITS'(1);
      cx0_in = 32'(wx0);
      cx1_in = 32'(wx1);
      cy0_in = 32'(wy0);
      cy1_in = 32'(wy1);
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         cx0_ff <= cx0_in;
         cx1_ff <= cx1_in;
         cy0_ff <= cy0_in;
         cy1_ff <= cy1_in;
         fx0_ff <= point_x[FRAC_BITS-1:0];
         fy0_ff <= point_y[FRAC_BITS-1:0];
      end
   end

   // stage 1: first multiply on the two x corners
   logic [31:0] ax_in [2];
   logic [31:0] ax_ff [2];
   logic [31:0] cy0_1_ff, cy1_1_ff;
   logic [FRAC_BITS-1:0] fx1_ff, fy1_ff;

   always_comb begin
      ax_in[0] = cx0_ff * HASH_M1;
      ax_in[1] = cx1_ff * HASH_M1;
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         ax_ff    <= ax_in;
         cy0_1_ff <= cy0_ff;
         cy1_1_ff <= cy1_ff;
         fx1_ff   <= fx0_ff;
         fy1_ff   <= fy0_ff;
      end
   end

   // stage 2: mix y into each corner; corner order 00, 10, 01, 11
   logic [31:0] a2_in [4];
   logic [31:0] b2_in [4];
   logic [31:0] a2_ff [4];
   logic [31:0] b2_ff [4];
   logic [FRAC_BITS-1:0] fx2_ff, fy2_ff;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         a2_in[c] = ax_ff[c % 2];
         b2_in[c] = ((c / 2 == 0 ? cy0_1_ff : cy1_1_ff) ^ rot16(a2_in[c])) * HASH_M2;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         a2_ff  <= a2_in;
         b2_ff  <= b2_in;
         fx2_ff <= fx1_ff;
         fy2_ff <= fy1_ff;
      end
   end

   // stage 3: final mix
   logic [31:0] h_in [4];
   logic [31:0] h_ff [4];
   logic [FRAC_BITS-1:0] fx3_ff, fy3_ff;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         h_in[c] = (a2_ff[c] ^ rot16(b2_ff[c])) * HASH_M3;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         h_ff   <= h_in;
         fx3_ff <= fx2_ff;
         fy3_ff <= fy2_ff;
      end
   end

   assign hash   = h_ff;
   assign frac_x = fx3_ff;
   assign frac_y = fy3_ff;

endmodule

>>> rtl/gn2d_grad.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn2d_grad
// Gradient lookup from the hash angle and the four corner dot products
// (stages 4 and 5).
// ----------------------------------------------------------------------------
module gn2d_grad #(
   parameter int FRAC_BITS  = 16,
   parameter int ANGLE_BITS = 10
) (
   input  logic                             clock,
   input  logic [1:0]                       stage_en,
   input  logic [31:0]                      hash [4],
   input  logic [FRAC_BITS-1:0]             frac_x,
   input  logic [FRAC_BITS-1:0]             frac_y,
   output logic signed [gn2d_pkg::DOT_W-1:0] dot [4]
);
   import gn2d_pkg::*;

   localparam int R_BITS = ANGLE_BITS - 2;
   localparam int TAB_D  = 1 << R_BITS;

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   // first-quadrant cos/sin table, built at elaboration
   logic [33:0] trig_tab [TAB_D];

   for (genvar i = 0; i < TAB_D; i++) begin : g_tab
      localparam logic [33:0] ENTRY = trig_entry(i, ANGLE_BITS);
      assign trig_tab[i] = ENTRY;
   end

   // stage 4: angle to gradient with quadrant symmetry
   logic signed [16:0] gx_in [4];
   logic signed [16:0] gy_in [4];
   logic signed [16:0] gx_ff [4];
   logic signed [16:0] gy_ff [4];
   logic [FRAC_BITS-1:0] fx_ff, fy_ff;
   logic [ANGLE_BITS-1:0] ang [4];
   logic [33:0]           ent [4];
   logic signed [16:0]    cv [4];
   logic signed [16:0]    sv [4];

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         ang[c] = hash[c][31 -: ANGLE_BITS];
         ent[c] = trig_tab[ang[c][R_BITS-1:0]];
         cv[c]  = signed'(ent[c][33:17]);
         sv[c]  = signed'(ent[c][16:0]);
         unique case (ang[c][ANGLE_BITS-1 -: 2])
            QUAD_0: begin gx_in[c] = cv[c];  gy_in[c] = sv[c];  end
            QUAD_1: begin gx_in[c] = -sv[c]; gy_in[c] = cv[c];  end
            QUAD_2: begin gx_in[c] = -cv[c]; gy_in[c] = -sv[c]; end
            QUAD_3: begin gx_in[c] = sv[c];  gy_in[c] = -cv[c]; end
            default: begin gx_in[c] = cv[c]; gy_in[c] = sv[c];  end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         gx_ff <= gx_in;
         gy_ff <= gy_in;
         fx_ff <= frac_x;
         fy_ff <= frac_y;
      end
   end

   // stage 5: dot with the offset to each corner, scaled to Q23
   logic signed [FRAC_BITS:0]    dx [4];
   logic signed [FRAC_BITS:0]    dy [4];
   logic signed [FRAC_BITS+18:0] sum [4];
   logic signed [FRAC_BITS+18:0] sh [4];
   logic signed [DOT_W-1:0]      d_in [4];
   logic signed [DOT_W-1:0]      d_ff [4];

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         // offset to the plus-one corner is frac minus one
         dx[c]   = signed'({(c % 2 == 1), fx_ff});
         dy[c]   = signed'({(c / 2 == 1), fy_ff});
         sum[c]  = gx_ff[c] * dx[c] + gy_ff[c] * dy[c];
         sh[c]   = sum[c] >>> (FRAC_BITS - 8);
         d_in[c] = sh[c][DOT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         d_ff <= d_in;
      end
   end

   assign dot = d_ff;

endmodule

>>> rtl/gn2d_fade.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn2d_fade
// Fade weights 3t^2 - 2t^3 of both fractions (stages 0 and 1), delayed to
// line up with the dot products at stage 5.
// ----------------------------------------------------------------------------
module gn2d_fade #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic [5:0]           stage_en,
   input  logic [FRAC_BITS-1:0] frac_x,
   input  logic [FRAC_BITS-1:0] frac_y,
   output logic [FRAC_BITS:0]   fade_x,
   output logic [FRAC_BITS:0]   fade_y
);
   localparam int F = FRAC_BITS;
   localparam logic [F+1:0] THREE_ONE = (F+2)'(3) << F;

   // stage 0: t squared
   logic [2*F-1:0] sqx, sqy;
   logic [F-1:0]   t2x_ff, t2y_ff, tx_ff, ty_ff;

   always_comb begin
      sqx = (2*F)'(frac_x) * (2*F)'(frac_x);
      sqy = (2*F)'(frac_y) * (2*F)'(frac_y);
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         t2x_ff <= sqx[2*F-1:F];
         t2y_ff <= sqy[2*F-1:F];
         tx_ff  <= frac_x;
         ty_ff  <= frac_y;
      end
   end

   // stage 1: t2 * (3 - 2t)
   logic [F+1:0]   mx, my;
   logic [2*F+1:0] px, py;
   logic [F:0]     fd_ff [1:5][2];

   always_comb begin
      mx = THREE_ONE - (F+2)'({tx_ff, 1'b0});
      my = THREE_ONE - (F+2)'({ty_ff, 1'b0});
      px = (2*F+2)'(t2x_ff) * (2*F+2)'(mx);
      py = (2*F+2)'(t2y_ff) * (2*F+2)'(my);
   end

   // stage 1 result, then stages 2 to 5 as a delay line
   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         fd_ff[1][0] <= px[2*F:F];
         fd_ff[1][1] <= py[2*F:F];
      end
      for (int s = 2; s <= 5; s++) begin
         if (stage_en[s]) begin
            fd_ff[s] <= fd_ff[s-1];
         end
      end
   end

   assign fade_x = fd_ff[5][0];
   assign fade_y = fd_ff[5][1];

endmodule

>>> rtl/gn2d_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn2d_blend
// Bilinear blend of the corner dots by the fade weights, then rounding and
// saturation to Q1.15 (stages 6 to 10, the last one is the output register).
// ----------------------------------------------------------------------------
module gn2d_blend #(
   parameter int FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic [4:0]                        stage_en,
   input  logic signed [gn2d_pkg::DOT_W-1:0] dot [4],
   input  logic [FRAC_BITS:0]                fade_x,
   input  logic [FRAC_BITS:0]                fade_y,
   output logic signed [15:0]                noise
);
   import gn2d_pkg::*;

   localparam int P_W = DOT_W + FRAC_BITS + 2;

   localparam logic signed [19:0] SAT_HI = 20'sd32767;
   localparam logic signed [19:0] SAT_LO = -20'sd32768;

   // stage 6: x-direction weighted differences
   logic signed [DOT_W:0]   dfa, dfb;
   logic signed [P_W-1:0]   pa_ff, pb_ff;
   logic signed [DOT_W-1:0] lo_a_ff, lo_b_ff;
   logic [FRAC_BITS:0]      fy6_ff;

   always_comb begin
      dfa = (DOT_W+1)'(dot[1]) - (DOT_W+1)'(dot[0]);
      dfb = (DOT_W+1)'(dot[3]) - (DOT_W+1)'(dot[2]);
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         pa_ff   <= dfa * signed'({1'b0, fade_x});
         pb_ff   <= dfb * signed'({1'b0, fade_x});
         lo_a_ff <= dot[0];
         lo_b_ff <= dot[2];
         fy6_ff  <= fade_y;
      end
   end

   // stage 7: x-direction lerp results
   logic signed [P_W-1:0]   sha, shb;
   logic signed [DOT_W-1:0] ea_ff, eb_ff;
   logic [FRAC_BITS:0]      fy7_ff;

   always_comb begin
      sha = pa_ff >>> FRAC_BITS;
      shb = pb_ff >>> FRAC_BITS;
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         ea_ff  <= lo_a_ff + sha[DOT_W-1:0];
         eb_ff  <= lo_b_ff + shb[DOT_W-1:0];
         fy7_ff <= fy6_ff;
      end
   end

   // stage 8: y-direction weighted difference
   logic signed [DOT_W:0]   dfz;
   logic signed [P_W-1:0]   pz_ff;
   logic signed [DOT_W-1:0] lo_z_ff;

   assign dfz = (DOT_W+1)'(eb_ff) - (DOT_W+1)'(ea_ff);

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         pz_ff   <= dfz * signed'({1'b0, fy7_ff});
         lo_z_ff <= ea_ff;
      end
   end

   // stage 9: final lerp
   logic signed [P_W-1:0]   shz;
   logic signed [DOT_W-1:0] z_ff;

   assign shz = pz_ff >>> FRAC_BITS;

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         z_ff <= lo_z_ff + shz[DOT_W-1:0];
      end
   end

   // stage 10: round Q23 to Q15 and saturate
   logic signed [DOT_W:0] zr, zs;
   logic signed [19:0]    q;
   logic signed [15:0]    q_in, q_ff;

   always_comb begin
      zr = (DOT_W+1)'(z_ff) + (DOT_W+1)'(128);
      zs = zr >>> 8;
      q  = zs[19:0];
      priority if (q > SAT_HI) q_in = SAT_HI[15:0];
      else if (q < SAT_LO)     q_in = SAT_LO[15:0];
      else                     q_in = q[15:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         q_ff <= q_in;
      end
   end

   assign noise = q_ff;

endmodule

>>> dv/gradient_noise_2d_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_noise_2d_tb
// Streams points into the noise core and compares every sample with an
// in-bench fixed-point predictor; random gaps on both sides and a long
// output hold-off that fills the pipeline.
// ----------------------------------------------------------------------------
module gradient_noise_2d_tb;
   import gn2d_pkg::*;

   localparam int IB = DEF_INT_BITS;
   localparam int FB = DEF_FRAC_BITS;
   localparam int AB = DEF_ANGLE_BITS;
   localparam int DOTQ = 23;
   localparam longint LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_x_coord = '0;
   logic signed [31:0] req_y_coord = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_noise_value;

   logic signed [15:0] sample_q[$];
   int errors = 0;
   longint cycle_count = 0;
   bit quiet_mode = 0;      // no random gaps
   bit hold_out = 0;        // long output hold-off
   int idle_pct = 30;

   gradient_noise_2d dut (.*);

   always #2 clock = ~clock;

   // cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // floor shift for signed 64-bit
   function automatic longint floor_shr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint wrap_int(longint v);
      logic [IB-1:0] u;
      u = v[IB-1:0];
      return longint'($signed(u));
   endfunction

   function automatic logic [31:0] mix_hash(longint cx, longint cy);
      logic [31:0] a, b;
      a = cx[31:0];
      b = cy[31:0];
      a = a * HASH_M1;
      b = b ^ {a[15:0], a[31:16]};
      b = b * HASH_M2;
      a = a ^ {b[15:0], b[31:16]};
      a = a * HASH_M3;
      return a;
   endfunction

   function automatic longint round_q15(longint v);
      if (v < 0) v = 0;
      return (v + (64'sd1 << 14)) >>> 15;
   endfunction

   // unit gradient from hash angle
   function automatic void grad_of(logic [31:0] h, output longint gx, output longint gy);
      int sdiv[5] = '{110, 72, 42, 20, 6};
      int cdiv[6] = '{132, 90, 56, 30, 12, 2};
      logic [AB-1:0] k;
      logic [1:0] quad;
      longint r, x, x2, t, c, s;
      k = h[31 -: AB];
      quad = k[AB-1 -: 2];
      r = k[AB-3:0];
      x = (r * 64'sd1686629713) >>> (AB - 2);
      x2 = (x * x) >>> 30;
      t = 64'sd1 << 30;
      for (int i = 0; i < 5; i++) begin
         t = (64'sd1 << 30) - ((x2 * t) >>> 30) / sdiv[i];
         if (t < 0) t = 0;
      end
      s = round_q15((x * t) >>> 30);
      t = 64'sd1 << 30;
      for (int i = 0; i < 6; i++) begin
         t = (64'sd1 << 30) - ((x2 * t) >>> 30) / cdiv[i];
         if (t < 0) t = 0;
      end
      c = round_q15(t);
      case (quad)
         2'd0: begin gx = c; gy = s; end
         2'd1: begin gx = -s; gy = c; end
         2'd2: begin gx = -c; gy = -s; end
         default: begin gx = s; gy = -c; end
      endcase
   endfunction

   function automatic longint corner_term(longint cx, longint cy, longint dx, longint dy);
      longint gx, gy;
      grad_of(mix_hash(cx, cy), gx, gy);
      return floor_shr(gx * dx + gy * dy, 15 + FB - DOTQ);
   endfunction

   function automatic longint ease(longint t);
      longint t2;
      t2 = (t * t) >>> FB;
      return (t2 * (3 * (64'sd1 << FB) - 2 * t)) >>> FB;
   endfunction

   function automatic longint lerp(longint lo, longint hi, longint w);
      return lo + floor_shr((hi - lo) * w, FB);
   endfunction

   function automatic logic signed [15:0] noise_at(logic signed [31:0] px,
                                                   logic signed [31:0] py);
      longint one, fx, fy, x0, y0, x1, y1, d00, d10, d01, d11, sx, sy, a, b, z, q;
      one = 64'sd1 << FB;
      fx = longint'(px) & (one - 1);
      fy = longint'(py) & (one - 1);
      x0 = wrap_int(longint'(px) >>> FB);
      y0 = wrap_int(longint'(py) >>> FB);
      x1 = wrap_int(x0 + 1);
      y1 = wrap_int(y0 + 1);
      d00 = corner_term(x0, y0, fx, fy);
      d10 = corner_term(x1, y0, fx - one, fy);
      d01 = corner_term(x0, y1, fx, fy - one);
      d11 = corner_term(x1, y1, fx - one, fy - one);
      sx = ease(fx);
      sy = ease(fy);
      a = lerp(d00, d10, sx);
      b = lerp(d01, d11, sx);
      z = lerp(a, b, sy);
      q = floor_shr(z + (64'sd1 << (DOTQ - 16)), DOTQ - 15);
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
   endfunction

   // send one point beat; valid stays up until the next idle cycle
   task automatic send_point(logic signed [31:0] x, logic signed [31:0] y);
      while (!quiet_mode && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_x_coord <= x;
      req_y_coord <= y;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sample_q.push_back(noise_at(x, y));
      @(negedge clock);
   endtask

   // output stall driver
   always @(negedge clock) begin
      if (hold_out) rsp_stall <= 1'b1;
      else if (quiet_mode) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < idle_pct);
   end

   // sample checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (sample_q.size() == 0) begin
            $display("%0t: unexpected sample, actual %0d", $time, rsp_noise_value);
            errors++;
         end else begin
            logic signed [15:0] exp_v;
            exp_v = sample_q.pop_front();
            if (exp_v !== rsp_noise_value) begin
               $display("%0t: noise mismatch, expected %0d actual %0d",
                        $time, exp_v, rsp_noise_value);
               errors++;
            end
         end
      end
   end

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return {{16{1'b0}}, 16'($urandom)} - 32'sd32768 + ($urandom_range(15) << 16);
         2: return {16'($urandom_range(8) - 4), 16'($urandom)};
         default: return {16'($urandom), 16'h0};
      endcase
   endfunction

   // extremes, lattice points and wrap corners
   task automatic test_directed();
      logic signed [31:0] vals[10] = '{32'sh0, 32'sh7fffffff, 32'sh80000000, 32'shffffffff,
         32'sh00010000, 32'sh7fff0000, 32'shffff0000, 32'sh00008000, 32'sh0001ffff,
         32'sh12345678};
      for (int i = 0; i < 10; i++) send_point(vals[i], vals[(i * 3 + 1) % 10]);
      for (int i = 0; i < 8; i++) send_point(vals[i], vals[i]);
   endtask

   task automatic test_random(int n);
      for (int i = 0; i < n; i++) send_point(rand_coord(), rand_coord());
   endtask

   // back-to-back stream with no gaps
   task automatic test_streaming();
      quiet_mode = 1;
      test_random(150);
      quiet_mode = 0;
   endtask

   // output held off so the pipeline backs up into the input
   task automatic test_backpressure();
      quiet_mode = 1;
      hold_out = 1;
      fork
         test_random(40);
         begin
            repeat (60) @(posedge clock);
            hold_out = 0;
         end
      join
      quiet_mode = 0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(350);
      test_streaming();
      test_backpressure();
      test_random(350);
      req_valid <= 1'b0;
      while (sample_q.size() != 0) @(posedge clock);
      repeat (STAGES + 10) @(posedge clock);
      if (errors == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end
endmodule

>>> filelist.f
rtl/gn2d_pkg.sv
rtl/gn2d_hash.sv
rtl/gn2d_grad.sv
rtl/gn2d_fade.sv
rtl/gn2d_blend.sv
rtl/gradient_noise_2d.sv
dv/gradient_noise_2d_tb.sv
